### rtl/core/border_line_color_recorder_macros.svh
// Assertion macros used by the border line color recorder checker.
`ifndef BORDER_LINE_COLOR_RECORDER_MACROS_SVH
`define BORDER_LINE_COLOR_RECORDER_MACROS_SVH

`define BLCR_ASSERT_SAME(label, cond, prop) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |-> (prop)) \
      else $error("border line color recorder: same-cycle check failed");

`define BLCR_ASSERT_NEXT(label, cond, prop) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |=> (prop)) \
      else $error("border line color recorder: next-cycle check failed");

`endif

### rtl/core/blcr_pkg.sv
// Types and constants of the border line color recorder.
package blcr_pkg;

   localparam int COLOR_W       = 8;
   localparam int TICK_W        = 17;
   localparam int LINE_W        = 8;
   localparam int FILL_POS_W    = 8;
   localparam int SPAN_W        = 16;
   localparam int CSR_ADDR_W    = 3;
   localparam int CSR_DATA_W    = 32;
   localparam logic [TICK_W-1:0] WINDOW_START_RESET = 17'd4096;

   typedef enum logic [1:0] {
      CMD_WRITE  = 2'd0,
      CMD_FINISH = 2'd1,
      CMD_START  = 2'd2,
      CMD_READ   = 2'd3
   } cmd_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_DIV,
      ST_FILL,
      ST_READ
   } state_type;

   typedef struct packed {
      cmd_type             cmd;
      logic [COLOR_W-1:0]  color;
      logic [TICK_W-1:0]   ticks;
      logic [LINE_W-1:0]   line;
   } req_type;

   typedef struct packed {
      logic [COLOR_W-1:0]    line_color;
      logic [FILL_POS_W-1:0] fill_position;
   } rsp_type;

endpackage

### rtl/core/blcr_csr.sv
// APB register holding the window start tick.
module blcr_csr
   import blcr_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready,
   output logic [TICK_W-1:0]     window_start
);

   logic [TICK_W-1:0] window_ff;
   logic [TICK_W-1:0] window_in;
   logic              sel_window;

   assign sel_window = (paddr[CSR_ADDR_W-1] == 1'b0);
   assign pready     = 1'b1;

   always_comb begin
      window_in = window_ff;
      if (psel && penable && pwrite && pready && sel_window) begin
         window_in = pwdata[TICK_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff <= WINDOW_START_RESET;
      end else begin
         window_ff <= window_in;
      end
   end

   assign prdata       = sel_window ? CSR_DATA_W'(window_ff) : '0;
   assign window_start = window_ff;

endmodule

### rtl/core/blcr_engine.sv
// Command sequencer and line color memory of the border line color recorder.
module blcr_engine
   import blcr_pkg::*;
#(
   parameter int NUM_LINES = 224
)(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  req_type           req,
   input  logic [TICK_W-1:0] window_start,
   output logic              busy,
   output logic              rsp_valid,
   output rsp_type           rsp
);

   localparam int FPW = $clog2(NUM_LINES + 1);
   localparam int AW  = $clog2(NUM_LINES);
   localparam int PW  = SPAN_W + FPW;
   localparam int QW  = PW - SPAN_W + 1;
   localparam int CW  = (FPW > LINE_W) ? FPW : LINE_W;

   logic [COLOR_W-1:0] line_mem [NUM_LINES];

   state_type          state_ff, state_in;
   logic [FPW-1:0]     fp_ff, fp_in;
   logic [COLOR_W-1:0] cur_ff, cur_in;
   logic [COLOR_W-1:0] new_color_ff, new_color_in;
   logic               is_write_ff, is_write_in;
   logic [SPAN_W-1:0]  diff_ff, diff_in;
   logic [PW-1:0]      prod_ff, prod_in;
   logic [FPW-1:0]     target_ff, target_in;
   logic               rd_ok_ff, rd_ok_in;
   logic [COLOR_W-1:0] rd_data_ff;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_ff, rsp_in;

   logic               mem_we;
   logic [AW-1:0]      mem_waddr;
   logic [COLOR_W-1:0] mem_wdata;
   logic               mem_re;
   logic [AW-1:0]      mem_raddr;

   logic [TICK_W:0]    tick_diff;
   logic [PW:0]        div_sum;
   logic [QW-1:0]      quot;
   logic               accept;

   assign busy   = (state_ff != ST_IDLE);
   assign accept = start && (state_ff == ST_IDLE);

   assign tick_diff = {1'b0, req.ticks} - {1'b0, window_start};
   assign div_sum   = {1'b0, prod_ff} + (PW + 1)'(prod_ff >> SPAN_W) + (PW + 1)'(1);
   assign quot      = div_sum[PW:SPAN_W];

   always_comb begin
      state_in     = state_ff;
      fp_in        = fp_ff;
      cur_in       = cur_ff;
      new_color_in = new_color_ff;
      is_write_in  = is_write_ff;
      diff_in      = diff_ff;
      prod_in      = prod_ff;
      target_in    = target_ff;
      rd_ok_in     = rd_ok_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      mem_we       = 1'b0;
      mem_waddr    = fp_ff[AW-1:0];
      mem_wdata    = cur_ff;
      mem_re       = 1'b0;
      mem_raddr    = AW'(req.line);

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               unique case (req.cmd)
                  CMD_WRITE: begin
                     new_color_in = req.color;
                     is_write_in  = 1'b1;
                     diff_in      = tick_diff[SPAN_W-1:0];
                     if (tick_diff[TICK_W:SPAN_W] == '0) begin
                        state_in = ST_MUL;
                     end else begin
                        cur_in       = req.color;
                        rsp_valid_in = 1'b1;
                        rsp_in       = '{line_color: '0, fill_position: FILL_POS_W'(fp_ff)};
                     end
                  end
                  CMD_FINISH: begin
                     is_write_in = 1'b0;
                     target_in   = FPW'(NUM_LINES);
                     state_in    = ST_FILL;
                  end
                  CMD_START: begin
                     fp_in        = '0;
                     rsp_valid_in = 1'b1;
                     rsp_in       = '{line_color: '0, fill_position: '0};
                  end
                  CMD_READ: begin
                     mem_re   = 1'b1;
                     rd_ok_in = (CW'(req.line) < CW'(fp_ff));
                     state_in = ST_READ;
                  end
               endcase
            end
         end
         ST_MUL: begin
            prod_in  = PW'(diff_ff) * PW'(NUM_LINES);
            state_in = ST_DIV;
         end
         ST_DIV: begin
            target_in = (quot > QW'(NUM_LINES)) ? FPW'(NUM_LINES) : quot[FPW-1:0];
            state_in  = ST_FILL;
         end
         ST_FILL: begin
            if (fp_ff < target_ff) begin
               mem_we = 1'b1;
               fp_in  = fp_ff + FPW'(1);
            end else begin
               if (is_write_ff) begin
                  if (fp_ff < FPW'(NUM_LINES)) begin
                     mem_we    = 1'b1;
                     mem_wdata = new_color_ff;
                     fp_in     = fp_ff + FPW'(1);
                  end
                  cur_in = new_color_ff;
               end
               rsp_valid_in = 1'b1;
               rsp_in       = '{line_color: '0, fill_position: FILL_POS_W'(fp_in)};
               state_in     = ST_IDLE;
            end
         end
         ST_READ: begin
            rsp_valid_in = 1'b1;
            rsp_in       = '{line_color: (rd_ok_ff ? rd_data_ff : '0),
                             fill_position: FILL_POS_W'(fp_ff)};
            state_in     = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         fp_ff        <= '0;
         cur_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fp_ff        <= fp_in;
         cur_ff       <= cur_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      new_color_ff <= new_color_in;
      is_write_ff  <= is_write_in;
      diff_ff      <= diff_in;
      prod_ff      <= prod_in;
      target_ff    <= target_in;
      rd_ok_ff     <= rd_ok_in;
      rsp_ff       <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         line_mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rd_data_ff <= line_mem[mem_raddr];
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

endmodule

### rtl/core/border_line_color_recorder.sv
// Top level of the border line color recorder.
//
// A request is taken at a rising clock edge with start high and busy low. Commands are
// border write, finish frame, start frame and read line. Each request gives exactly one
// response, shown on rsp_payload for one cycle with rsp_valid high; the receiver cannot
// stall it, and the block takes the next request while a response is still on the ports.
// A start frame and a border write outside the tick window answer in the next cycle and
// never go busy; a read answers after the busy read state. A border write inside the
// window maps its tick to a line in two steps (multiply, then divide by reciprocal), then
// writes one line per cycle through the single write port of the line memory, first the
// old color up to the mapped line, then its own color if room is left, and answers.
// Finish frame fills the rest with the current color. The fill pointer both counts the
// lines written this frame and marks which lines read back valid, so the line memory is
// never cleared. Reset clears the fill pointer and the current color and sets the window
// start to 4096; it takes effect at the next edge. The window start register sits at APB
// address 0 and is written by the user only while idle; the block does not enforce it.
module border_line_color_recorder
   import blcr_pkg::*;
#(
   parameter int ACTIVE_LINES = 192,
   parameter int BORDER_LINES = 16
)(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  req_type               req_payload,
   output logic                  rsp_valid,
   output rsp_type               rsp_payload,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);

   localparam int NUM_LINES = ACTIVE_LINES + 2 * BORDER_LINES;

   logic [TICK_W-1:0] window_start;

   blcr_csr u_csr (
      .clock        (clock),
      .reset        (reset),
      .psel         (psel),
      .penable      (penable),
      .pwrite       (pwrite),
      .paddr        (paddr),
      .pwdata       (pwdata),
      .prdata       (prdata),
      .pready       (pready),
      .window_start (window_start)
   );

   blcr_engine #(
      .NUM_LINES (NUM_LINES)
   ) u_engine (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .req          (req_payload),
      .window_start (window_start),
      .busy         (busy),
      .rsp_valid    (rsp_valid),
      .rsp          (rsp_payload)
   );

endmodule

### rtl/core/blcr_checker.sv
// Port-level checker of the border line color recorder and its bind.
`include "border_line_color_recorder_macros.svh"

module blcr_checker
   import blcr_pkg::*;
#(
   parameter int NUM_LINES = 224
)(
   input logic    clock,
   input logic    reset,
   input logic    start,
   input logic    busy,
   input req_type req_payload,
   input logic    rsp_valid,
   input rsp_type rsp_payload
);

   `BLCR_ASSERT_SAME(a_rsp_follows_request, rsp_valid, $past(busy) || $past(start))
   `BLCR_ASSERT_SAME(a_busy_end_responds, $fell(busy), rsp_valid)
   `BLCR_ASSERT_SAME(a_fill_in_range, rsp_valid, (NUM_LINES > 255) || (rsp_payload.fill_position <= NUM_LINES))
   `BLCR_ASSERT_NEXT(a_start_frame_rewinds, start && !busy && req_payload.cmd == CMD_START, rsp_valid && rsp_payload.fill_position == 0)

endmodule

bind border_line_color_recorder blcr_checker #(
   .NUM_LINES (ACTIVE_LINES + 2 * BORDER_LINES)
) u_blcr_checker (.*);
